FILE: hdl/touch_button_press_classifier_unit_macros.svh
// Assertion macros shared by the touch button press classifier RTL.
`ifndef TOUCH_BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH
`define TOUCH_BUTTON_PRESS_CLASSIFIER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TBPC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("tbpc check failed");

// Check a property on every clock edge, reset included.
`define TBPC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("tbpc check failed");

`endif

FILE: hdl/tbpc_pkg.sv
// Types and constants of the touch button press classifier.
package tbpc_pkg;

  localparam int unsigned PAD_COUNT = 3;
  localparam int unsigned READ_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [READ_W-1:0] THRESHOLD_RST   = 16'd17;
  localparam logic [READ_W-1:0] SHORT_LIMIT_RST = 16'd700;
  localparam logic [READ_W-1:0] LONG_LIMIT_RST  = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAD_THRESHOLD = 2'd0,
    CFG_SHORT_LIMIT   = 2'd1,
    CFG_LONG_LIMIT    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [READ_W-1:0] touch_0;
    logic [READ_W-1:0] touch_1;
    logic [READ_W-1:0] touch_2;
    logic              suppress;
  } in_item_t;

  typedef struct packed {
    logic [PAD_COUNT-1:0] touched_mask;
    logic [PAD_COUNT-1:0] short_mask;
    logic [PAD_COUNT-1:0] long_mask;
  } out_item_t;

  typedef struct packed {
    logic [READ_W-1:0] pad_threshold;
    logic [READ_W-1:0] short_limit_ms;
    logic [READ_W-1:0] long_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic touched;
    logic short_hit;
    logic long_hit;
  } pad_flags_t;

endpackage

FILE: hdl/tbpc_cfg_regs.sv
// Configuration registers: touch threshold and press time limits.
module tbpc_cfg_regs import tbpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [READ_W-1:0]    cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PAD_THRESHOLD: cfg_d.pad_threshold  = cfg_data_i;
        CFG_SHORT_LIMIT:   cfg_d.short_limit_ms = cfg_data_i;
        CFG_LONG_LIMIT:    cfg_d.long_limit_ms  = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pad_threshold  <= THRESHOLD_RST;
      cfg_q.short_limit_ms <= SHORT_LIMIT_RST;
      cfg_q.long_limit_ms  <= LONG_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/tbpc_pad_lane.sv
// One pad: touch detect, edge tracking, hold timing and press classification.
module tbpc_pad_lane import tbpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [READ_W-1:0] reading_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic              quiet_i,
  input  cfg_t              cfg_i,
  input  logic              update_i,
  output pad_flags_t        flags_o
);

  logic              last_q, last_d;
  logic              rep_q, rep_d;
  logic [TIME_W-1:0] rise_q, rise_d;
  logic              is_touched;
  logic              rising;
  logic              falling;
  logic [TIME_W-1:0] held;
  logic              short_hit;
  logic              long_hit;

  always_comb begin
    is_touched = reading_i < cfg_i.pad_threshold;
    rising     = !last_q && is_touched;
    falling    = last_q && !is_touched;
    rise_d     = rising ? now_i : rise_q;
    // Elapsed time wraps with the timestamp.
    held       = now_i - rise_d;
    short_hit  = !quiet_i && falling &&
                 (held < {{(TIME_W-READ_W){1'b0}}, cfg_i.short_limit_ms});
    long_hit   = !quiet_i && is_touched && !rep_q &&
                 (held > {{(TIME_W-READ_W){1'b0}}, cfg_i.long_limit_ms});
    last_d     = is_touched;
    rep_d      = rep_q;
    // Re-arm on release, latch on report; hold while suppressed.
    if (falling && !quiet_i) begin
      rep_d = 1'b0;
    end else if (long_hit) begin
      rep_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      rep_q  <= 1'b0;
      rise_q <= '0;
    end else if (update_i) begin
      last_q <= last_d;
      rep_q  <= rep_d;
      rise_q <= rise_d;
    end
  end

  assign flags_o.touched   = is_touched;
  assign flags_o.short_hit = short_hit;
  assign flags_o.long_hit  = long_hit;

endmodule

FILE: hdl/touch_button_press_classifier_unit.sv
// Throughput: one beat per cycle while out_stall_i does not hold the pipe;
// input register feeds per-pad logic, result register drives the output,
// pad state commits as a beat enters the result.
// Reset: rst_ni low clears both stages, pad state and loads register defaults.
// Top level of the touch button press classifier.
`include "touch_button_press_classifier_unit_macros.svh"
module touch_button_press_classifier_unit import tbpc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [READ_W-1:0]    cfg_data_i
);

  cfg_t                           cfg;
  logic                           s1_valid_q, s1_valid_d;
  in_item_t                       s1_data_q;
  logic                           out_valid_q, out_valid_d;
  out_item_t                      out_data_q, out_data_d;
  logic                           advance;
  logic                           accept;
  logic [PAD_COUNT-1:0][READ_W-1:0] readings;
  pad_flags_t [PAD_COUNT-1:0]     flags;

  tbpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Move the held beat on when the result register is free or draining.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign readings = {s1_data_q.touch_2, s1_data_q.touch_1, s1_data_q.touch_0};

  for (genvar p = 0; p < PAD_COUNT; p++) begin : g_pad
    tbpc_pad_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .reading_i (readings[p]),
      .now_i     (s1_data_q.time_ms),
      .quiet_i   (s1_data_q.suppress),
      .cfg_i     (cfg),
      .update_i  (advance),
      .flags_o   (flags[p])
    );
  end

  always_comb begin
    s1_valid_d  = accept || (s1_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
    for (int p = 0; p < PAD_COUNT; p++) begin
      out_data_d.touched_mask[p] = flags[p].touched;
      out_data_d.short_mask[p]   = flags[p].short_hit;
      out_data_d.long_mask[p]    = flags[p].long_hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_data_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `TBPC_ASSERT_ALWAYS(a_empty_no_stall, !s1_valid_q |-> !in_stall_o)
  `TBPC_ASSERT(a_advance_fills_out, advance |=> out_valid_q)
  `TBPC_ASSERT(a_short_released, out_valid_q |-> ((out_data_q.short_mask & out_data_q.touched_mask) == '0))
  `TBPC_ASSERT(a_long_touched, out_valid_q |-> ((out_data_q.long_mask & ~out_data_q.touched_mask) == '0))

endmodule
